// ===== design/bpau_pkg.sv =====
`timescale 1ns / 1ps

package bpau_pkg;

  // Pixel format codes.
  localparam logic [1:0] FMT_PAL1   = 2'd0;
  localparam logic [1:0] FMT_BGR24  = 2'd1;
  localparam logic [1:0] FMT_BGRA32 = 2'd2;
  localparam logic [1:0] FMT_NONE   = 2'd3;

  // Configuration register indexes.
  localparam int          CFG_IDX_W          = 3;
  localparam logic [2:0]  REG_IMAGE_WIDTH    = 3'd0;
  localparam logic [2:0]  REG_IMAGE_HEIGHT   = 3'd1;
  localparam logic [2:0]  REG_BOTTOM_UP      = 3'd2;
  localparam logic [2:0]  REG_PIXEL_FORMAT   = 3'd3;
  localparam logic [2:0]  REG_PALETTE_COLOR0 = 3'd4;
  localparam logic [2:0]  REG_PALETTE_COLOR1 = 3'd5;
  localparam int          CFG_DATA_W         = 24;

  // Depth of the job queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Configuration registers as written.
  typedef struct packed {
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic        bottom_up;
    logic [1:0]  pixel_format;
    logic [23:0] palette_color0;
    logic [23:0] palette_color1;
  } cfg_t;

  // One job: a single finished pixel, or a palette byte that yields a run of pixels.
  // For a single pixel, data holds {alpha, blue, green, red}; for a palette run,
  // data[7:0] holds the source byte.
  typedef struct packed {
    logic        is_palette;
    logic [31:0] data;
    logic [3:0]  count;
    logic [11:0] column;
    logic [11:0] image_row;
    logic        ends_frame;
  } job_t;

endpackage

// ===== design/bmp_pixel_array_unpacker.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Payload
// s_axis    in         tdata[7:0] data_byte
// m_axis    out        tdata: red, green, blue, alpha, column, image_row;
//                      tlast last_of_run; tuser frame_end
// cfg       in         cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// A 24-bit or 32-bit byte is taken every cycle while the queue has room, and
// every third or fourth byte yields one pixel. A 1-bit byte expands to up to
// eight pixels, one per cycle in the back end while m_axis is ready; the
// four-entry job queue absorbs short bursts. A pixel reaches m_axis through
// the job queue and then the output register.
// Reset clears the row counters and loads the default configuration.
// A stall on m_axis fills the queue, which then drops s_axis_tready.

module bmp_pixel_array_unpacker #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,  // [7:0] data_byte
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha,
  // [43:32] column, [55:44] image_row
  output logic [55:0]                        m_axis_tdata,
  output logic                               m_axis_tlast,
  output logic                               m_axis_tuser,  // [0] frame_end
  input  logic                               cfg_we_i,
  input  logic [bpau_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bpau_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  bpau_pkg::cfg_t cfg_q, cfg_d;
  bpau_pkg::job_t job_in;
  bpau_pkg::job_t job_head;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;

  // Configuration register writes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bpau_pkg::REG_IMAGE_WIDTH:    cfg_d.image_width    = cfg_data_i[12:0];
        bpau_pkg::REG_IMAGE_HEIGHT:   cfg_d.image_height   = cfg_data_i[12:0];
        bpau_pkg::REG_BOTTOM_UP:      cfg_d.bottom_up      = cfg_data_i[0];
        bpau_pkg::REG_PIXEL_FORMAT:   cfg_d.pixel_format   = cfg_data_i[1:0];
        bpau_pkg::REG_PALETTE_COLOR0: cfg_d.palette_color0 = cfg_data_i;
        bpau_pkg::REG_PALETTE_COLOR1: cfg_d.palette_color1 = cfg_data_i;
        default:                      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width    <= 13'd1;
      cfg_q.image_height   <= 13'd1;
      cfg_q.bottom_up      <= 1'b1;
      cfg_q.pixel_format   <= bpau_pkg::FMT_BGR24;
      cfg_q.palette_color0 <= 24'h000000;
      cfg_q.palette_color1 <= 24'hFFFFFF;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  bpau_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .queue_full_i (q_full),
    .push_o       (push),
    .job_o        (job_in)
  );

  bpau_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .data_o  (job_head)
  );

  bpau_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (!q_empty),
    .head_i       (job_head),
    .pop_o        (pop),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_o     (m_axis_tdata),
    .m_last_o     (m_axis_tlast),
    .m_user_o     (m_axis_tuser)
  );

endmodule

// ===== design/bpau_front.sv =====
`timescale 1ns / 1ps

module bpau_front #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bpau_pkg::cfg_t  cfg_i,
  input  logic            s_valid_i,
  output logic            s_ready_o,
  input  logic [7:0]      s_data_i,
  input  logic            queue_full_i,
  output logic            push_o,
  output bpau_pkg::job_t  job_o
);

  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int XW  = (CW > 13) ? CW : 13;
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int YW  = (HW > 13) ? HW : 13;
  localparam int RCW = $clog2(MAX_HEIGHT);
  localparam int BW  = $clog2(MAX_WIDTH * 4 + 1);
  localparam int RBW = $clog2(MAX_WIDTH * 4);
  localparam int DW  = (HW > 12) ? HW : 12;

  logic [CW-1:0]  col_q, col_d;
  logic [RBW-1:0] rbc_q, rbc_d;
  logic [RCW-1:0] src_q, src_d;
  logic [23:0]    asm_q, asm_d;
  logic [1:0]     phase_q, phase_d;

  logic [XW-1:0]  w_raw;
  logic [YW-1:0]  h_raw;
  logic [CW-1:0]  w;
  logic [HW-1:0]  h;
  logic [BW-1:0]  w_b;
  logic [BW-1:0]  row_len;
  logic           row_end;
  logic           last_row;
  logic [DW-1:0]  dest;
  logic           col_lt_w;
  logic [CW-1:0]  rem;
  logic [3:0]     pal_n;
  logic [3:0]     emit_n;
  logic [1:0]     last_phase;
  logic           accept;

  assign s_ready_o = !queue_full_i;
  assign accept    = s_valid_i && s_ready_o;

  // Clamp the image dimensions into their legal range.
  assign w_raw = XW'(cfg_i.image_width);
  assign h_raw = YW'(cfg_i.image_height);

  always_comb begin
    priority if (w_raw == '0) begin
      w = CW'(1);
    end else if (w_raw > XW'(MAX_WIDTH)) begin
      w = CW'(MAX_WIDTH);
    end else begin
      w = CW'(w_raw);
    end
    priority if (h_raw == '0) begin
      h = HW'(1);
    end else if (h_raw > YW'(MAX_HEIGHT)) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(h_raw);
    end
  end

  // Stored row length in bytes, padded to a multiple of four.
  assign w_b = BW'(w);

  always_comb begin
    unique case (cfg_i.pixel_format)
      bpau_pkg::FMT_PAL1:  row_len = ((w_b + BW'(31)) >> 5) << 2;
      bpau_pkg::FMT_BGR24: row_len = ((w_b + (w_b << 1) + BW'(3)) >> 2) << 2;
      default:             row_len = w_b << 2;
    endcase
  end

  assign row_end  = (BW'(rbc_q) + BW'(1)) >= row_len;
  assign last_row = (HW'(src_q) + HW'(1)) >= h;
  assign dest     = cfg_i.bottom_up ? (DW'(h) - DW'(1) - DW'(src_q)) : DW'(src_q);

  // Pixels left in the row bound the run of a palette byte.
  assign col_lt_w = col_q < w;
  assign rem      = w - col_q;
  assign pal_n    = (rem >= CW'(8)) ? 4'd8 : rem[3:0];

  assign last_phase = (cfg_i.pixel_format == bpau_pkg::FMT_BGR24) ? 2'd2 : 2'd3;

  // Classify the byte, build its job and advance the row counters.
  always_comb begin
    col_d   = col_q;
    rbc_d   = rbc_q;
    src_d   = src_q;
    asm_d   = asm_q;
    phase_d = phase_q;
    push_o  = 1'b0;
    emit_n  = 4'd1;
    job_o   = '0;

    job_o.column    = 12'(col_q);
    job_o.image_row = dest[11:0];

    if (accept && (cfg_i.pixel_format != bpau_pkg::FMT_NONE)) begin
      if (cfg_i.pixel_format == bpau_pkg::FMT_PAL1) begin
        if (col_lt_w) begin
          push_o           = 1'b1;
          emit_n           = pal_n;
          job_o.is_palette = 1'b1;
          job_o.data       = {24'h0, s_data_i};
          job_o.count      = pal_n;
          col_d            = col_q + CW'(pal_n);
        end
      end else if (phase_q < last_phase) begin
        asm_d   = asm_q | (24'(s_data_i) << {phase_q, 3'b000});
        phase_d = phase_q + 2'd1;
      end else begin
        if (col_lt_w) begin
          push_o      = 1'b1;
          job_o.count = 4'd1;
          if (cfg_i.pixel_format == bpau_pkg::FMT_BGR24) begin
            job_o.data = {8'hFF, asm_q[7:0], asm_q[15:8], s_data_i};
          end else begin
            job_o.data = {s_data_i, asm_q[7:0], asm_q[15:8], asm_q[23:16]};
          end
          col_d = col_q + CW'(1);
        end
        asm_d   = '0;
        phase_d = 2'd0;
      end

      if (row_end) begin
        rbc_d   = '0;
        col_d   = '0;
        phase_d = 2'd0;
        asm_d   = '0;
        src_d   = last_row ? '0 : (src_q + RCW'(1));
      end else begin
        rbc_d = rbc_q + RBW'(1);
      end
    end

    job_o.ends_frame = last_row && ((col_q + CW'(emit_n)) == w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      rbc_q   <= '0;
      src_q   <= '0;
      asm_q   <= '0;
      phase_q <= 2'd0;
    end else begin
      col_q   <= col_d;
      rbc_q   <= rbc_d;
      src_q   <= src_d;
      asm_q   <= asm_d;
      phase_q <= phase_d;
    end
  end

endmodule

// ===== design/bpau_queue.sv =====
`timescale 1ns / 1ps

module bpau_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bpau_pkg::job_t  data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output bpau_pkg::job_t  data_o
);

  localparam int PW = $clog2(bpau_pkg::QUEUE_DEPTH);

  bpau_pkg::job_t        mem_q [bpau_pkg::QUEUE_DEPTH];
  logic [PW-1:0]         wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [PW:0]           cnt_q, cnt_d;
  logic                  do_push;
  logic                  do_pop;

  assign full_o  = cnt_q == (PW + 1)'(bpau_pkg::QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_d = do_push ? (wr_ptr_q + PW'(1)) : wr_ptr_q;
    rd_ptr_d = do_pop ? (rd_ptr_q + PW'(1)) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (PW + 1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (PW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== design/bpau_back.sv =====
`timescale 1ns / 1ps

module bpau_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bpau_pkg::cfg_t  cfg_i,
  input  logic            head_valid_i,
  input  bpau_pkg::job_t  head_i,
  output logic            pop_o,
  output logic            m_valid_o,
  input  logic            m_ready_i,
  output logic [55:0]     m_data_o,
  output logic            m_last_o,
  output logic            m_user_o
);

  logic [2:0]  k_q, k_d;
  logic        out_vld_q, out_vld_d;
  logic [55:0] out_data_q;
  logic        out_last_q;
  logic        out_user_q;
  logic        load;
  logic        run_last;
  logic [7:0]  pbyte;
  logic        pbit;
  logic [23:0] pcolor;
  logic [31:0] rgba;
  logic [11:0] col;

  // The output register is free when empty or being drained this cycle.
  assign load     = head_valid_i && (!out_vld_q || m_ready_i);
  assign run_last = {1'b0, k_q} == (head_i.count - 4'd1);
  assign pop_o    = load && run_last;

  // Palette lookup, most significant bit first.
  assign pbyte  = head_i.data[7:0];
  assign pbit   = pbyte[3'd7 - k_q];
  assign pcolor = pbit ? cfg_i.palette_color1 : cfg_i.palette_color0;
  assign rgba   = head_i.is_palette ? {8'hFF, pcolor[7:0], pcolor[15:8], pcolor[23:16]}
                                    : head_i.data;
  assign col    = head_i.column + 12'(k_q);

  always_comb begin
    k_d = k_q;
    if (load) begin
      k_d = run_last ? 3'd0 : (k_q + 3'd1);
    end
    out_vld_d = out_vld_q;
    if (load) begin
      out_vld_d = 1'b1;
    end else if (m_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q       <= 3'd0;
      out_vld_q <= 1'b0;
    end else begin
      k_q       <= k_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= {head_i.image_row, col, rgba};
      out_last_q <= run_last;
      out_user_q <= run_last && head_i.ends_frame;
    end
  end

  assign m_valid_o = out_vld_q;
  assign m_data_o  = out_data_q;
  assign m_last_o  = out_last_q;
  assign m_user_o  = out_user_q;

endmodule
